>>> hw/rtl/tzke_pkg.sv
// Shared types, constants and the zone map of the touch zone key encoder.
package tzke_pkg;

  // Stream widths; the data buses are padded to whole bytes.
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  // At most this many events leave for one sample.
  localparam int unsigned MaxEvents = 4;
  localparam int unsigned NumButtons = 9;

  // Reset values of the configuration registers.
  localparam logic [15:0] ExitHoldReset   = 16'd2000;
  localparam logic [7:0]  CornerSizeReset = 8'd50;
  localparam logic [7:0]  DeadZoneReset   = 8'd22;

  // Screen geometry.
  localparam logic [8:0] LeftZoneEnd   = 9'd160;
  localparam logic [8:0] RightZoneBase = 9'd320;
  localparam logic [8:0] FireUseSplit  = 9'd160;
  localparam logic [8:0] EscapeEnd     = 9'd90;
  localparam logic [8:0] EnterEnd      = 9'd220;
  localparam logic [9:0] DpadCentreX   = 10'd80;
  localparam logic [9:0] DpadCentreY   = 10'd200;

  // Button numbers, also the bit positions in a button mask.
  localparam int unsigned BtnUp     = 0;
  localparam int unsigned BtnDown   = 1;
  localparam int unsigned BtnLeft   = 2;
  localparam int unsigned BtnRight  = 3;
  localparam int unsigned BtnFire   = 4;
  localparam int unsigned BtnUse    = 5;
  localparam int unsigned BtnEscape = 6;
  localparam int unsigned BtnEnter  = 7;
  localparam int unsigned BtnWeapon = 8;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TAP     = 2'd2,
    KIND_EXIT    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_EXIT_HOLD   = 2'd0,
    REG_CORNER_SIZE = 2'd1,
    REG_DEAD_ZONE   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        touch_down;
    logic [8:0]  touch_x;
    logic [8:0]  touch_y;
    logic [31:0] time_ms;
    logic        menu_open;
    logic        setup_screen;
  } sample_t;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] button;
    logic [8:0] tap_x;
    logic [8:0] tap_y;
    logic       last;
  } ev_t;

  typedef struct packed {
    logic [NumButtons-1:0] held_mask;
    logic                  was_touching;
    logic                  wait_for_release;
    logic                  corner_armed;
    logic [31:0]           corner_start_ms;
  } state_t;

  typedef struct packed {
    logic [15:0] exit_hold_ms;
    logic [7:0]  exit_corner_size;
    logic [7:0]  dpad_dead_zone;
  } cfg_t;

  // Buttons covered by a touch at (x, y) outside the exit corner.
  function automatic logic [NumButtons-1:0] zone_mask(logic [8:0] x, logic [8:0] y,
                                                      logic [7:0] dz);
    logic [NumButtons-1:0] m;
    logic [9:0] xe;
    logic [9:0] ye;
    logic [9:0] dze;
    m   = '0;
    xe  = {1'b0, x};
    ye  = {1'b0, y};
    dze = {2'b00, dz};
    if (x < LeftZoneEnd) begin
      // D-pad: an offset counts only once it passes the dead zone.
      if (ye + dze < DpadCentreY) begin
        m[BtnUp] = 1'b1;
      end else if (ye > DpadCentreY + dze) begin
        m[BtnDown] = 1'b1;
      end
      if (xe + dze < DpadCentreX) begin
        m[BtnLeft] = 1'b1;
      end else if (xe > DpadCentreX + dze) begin
        m[BtnRight] = 1'b1;
      end
    end else if (x >= RightZoneBase) begin
      if (y < FireUseSplit) begin
        m[BtnFire] = 1'b1;
      end else begin
        m[BtnUse] = 1'b1;
      end
    end else if (y < EscapeEnd) begin
      m[BtnEscape] = 1'b1;
    end else if (y < EnterEnd) begin
      m[BtnEnter] = 1'b1;
    end else begin
      m[BtnWeapon] = 1'b1;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/tzke_decode.sv
// Per-sample decode: zone map, corner timer, menu handling and event list.
module tzke_decode (
  input  tzke_pkg::sample_t                         sample_i,
  input  tzke_pkg::state_t                          state_i,
  input  tzke_pkg::cfg_t                            cfg_i,
  output tzke_pkg::ev_t [tzke_pkg::MaxEvents-1:0]   events_o,
  output logic [2:0]                                num_events_o,
  output tzke_pkg::state_t                          state_o
);

  logic                            menu;
  logic                            press;
  logic                            in_corner;
  logic                            run_check;
  logic                            fire;
  logic                            do_changes;
  logic [tzke_pkg::NumButtons-1:0] now;
  logic [tzke_pkg::NumButtons-1:0] changed;
  logic [2:0]                      cnt;

  assign menu  = sample_i.menu_open & ~sample_i.setup_screen;
  assign press = sample_i.touch_down & ~state_i.was_touching;

  // Finger inside the top-left square; a size of zero gives no corner.
  assign in_corner = sample_i.touch_down
                   && (sample_i.touch_x < {1'b0, cfg_i.exit_corner_size})
                   && (sample_i.touch_y < {1'b0, cfg_i.exit_corner_size});

  // The corner timer runs in menu mode with nothing held, and in game mode
  // while the finger is down and no release wait is pending.
  assign run_check = menu ? (state_i.held_mask == '0)
                          : (sample_i.touch_down & ~state_i.wait_for_release);

  assign fire = run_check && in_corner && state_i.corner_armed
             && ((sample_i.time_ms - state_i.corner_start_ms)
                 > {16'd0, cfg_i.exit_hold_ms});

  // Target button mask and whether held buttons are compared against it.
  always_comb begin
    now        = '0;
    do_changes = 1'b0;
    if (menu) begin
      do_changes = (state_i.held_mask != '0);
    end else begin
      do_changes = ~fire;
      if (run_check && !in_corner) begin
        now = tzke_pkg::zone_mask(sample_i.touch_x, sample_i.touch_y,
                                  cfg_i.dpad_dead_zone);
      end
    end
  end

  assign changed = now ^ state_i.held_mask;

  // Build the event list and the next state.
  always_comb begin
    events_o = '0;
    cnt      = 3'd0;
    state_o  = state_i;

    state_o.was_touching     = sample_i.touch_down;
    state_o.wait_for_release = state_i.wait_for_release & sample_i.touch_down;

    if (run_check) begin
      if (!in_corner) begin
        state_o.corner_armed = 1'b0;
      end else if (!state_i.corner_armed) begin
        state_o.corner_armed    = 1'b1;
        state_o.corner_start_ms = sample_i.time_ms;
      end
    end

    if (do_changes) begin
      // Changed buttons in ascending order; those past the fourth are dropped.
      for (int b = 0; b < tzke_pkg::NumButtons; b++) begin
        if (changed[b] && !cnt[2]) begin
          events_o[cnt[1:0]].kind   = now[b] ? tzke_pkg::KIND_PRESS
                                             : tzke_pkg::KIND_RELEASE;
          events_o[cnt[1:0]].button = 4'(b);
          cnt = cnt + 3'd1;
        end
      end
      state_o.held_mask = now;
    end else if (fire) begin
      events_o[0].kind = tzke_pkg::KIND_EXIT;
      cnt = 3'd1;
    end else if (menu && !in_corner && press) begin
      events_o[0].kind  = tzke_pkg::KIND_TAP;
      events_o[0].tap_x = sample_i.touch_x;
      events_o[0].tap_y = sample_i.touch_y;
      state_o.wait_for_release = 1'b1;
      cnt = 3'd1;
    end

    // Mark the final event of the sample.
    for (int k = 0; k < tzke_pkg::MaxEvents; k++) begin
      events_o[k].last = (cnt == 3'(k + 1));
    end
  end

  assign num_events_o = cnt;

endmodule

>>> hw/rtl/tzke_evq.sv
// Result queue: holds the events of one sample and sends them one a cycle while ready_i is high.
module tzke_evq (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     push_i,
  input  tzke_pkg::ev_t [tzke_pkg::MaxEvents-1:0]  events_i,
  input  logic [2:0]                               num_events_i,
  output logic                                     free_o,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output tzke_pkg::ev_t                            event_o
);

  tzke_pkg::ev_t [tzke_pkg::MaxEvents-1:0] q_q;
  logic [2:0]                              cnt_q;
  logic                                    pop;

  assign valid_o = (cnt_q != 3'd0);
  assign event_o = q_q[0];
  assign pop     = valid_o & ready_i;

  // A new list may enter once the last queued event leaves.
  assign free_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && ready_i);

  // Occupancy count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (push_i) begin
      cnt_q <= num_events_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  // Event storage; the head always sits in entry zero.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q <= events_i;
    end else if (pop) begin
      q_q <= {tzke_pkg::ev_t'('0), q_q[tzke_pkg::MaxEvents-1:1]};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(tzke_pkg::MaxEvents))
    else $error("event queue count out of range");

  a_last_at_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && event_o.last |-> cnt_q == 3'd1)
    else $error("last flag on an event that is not the tail");

  a_tail_has_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 3'd1 |-> event_o.last)
    else $error("tail event lacks the last flag");

endmodule

>>> hw/rtl/touch_zone_key_encoder.sv
// Top level of the touch zone key encoder: ports, registers and queue.
//
//   channel   direction  handshake                       contents
//   s_axis    in         s_axis_tvalid / s_axis_tready   one touch sample per transaction
//   m_axis    out        m_axis_tvalid / m_axis_tready   one key, tap or exit event
//   cfg       in         cfg_we_i                        register write, no read-back
//
// A sample is registered, decoded combinationally and its events (zero to four)
// written into the result queue, which sends one event per cycle while m_axis_tready is high.
// A sample with no events never enters the queue. The first event appears once the
// sample has passed the input register and the result queue register.
// Reset clears the control state and loads the register defaults; no clearing pass. Data registers are not reset.
// A stall on m_axis holds the queue; one further sample waits in the input
// register, and s_axis_tready falls only while that register cannot drain.
module touch_zone_key_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Bits from 0: touch_down, touch_x[8:0], touch_y[8:0], time_ms[31:0],
  // menu_open, setup_screen, zero padding.
  input  logic [tzke_pkg::InDataW-1:0]      s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Bits from 0: button[3:0], tap_x[8:0], tap_y[8:0], zero padding.
  output logic [tzke_pkg::OutDataW-1:0]     m_axis_tdata,
  // Bits from 0: event_kind[1:0].
  output logic [tzke_pkg::OutUserW-1:0]     m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [tzke_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tzke_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  tzke_pkg::cfg_t                          cfg_q;
  tzke_pkg::state_t                        state_q;
  tzke_pkg::state_t                        state_d;
  tzke_pkg::sample_t                       in_q;
  tzke_pkg::sample_t                       in_d;
  logic                                    in_vld_q;
  tzke_pkg::ev_t [tzke_pkg::MaxEvents-1:0] events;
  logic [2:0]                              num_events;
  logic                                    q_free;
  logic                                    consume;
  logic                                    push;
  tzke_pkg::ev_t                           ev_out;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.exit_hold_ms     <= tzke_pkg::ExitHoldReset;
      cfg_q.exit_corner_size <= tzke_pkg::CornerSizeReset;
      cfg_q.dpad_dead_zone   <= tzke_pkg::DeadZoneReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tzke_pkg::REG_EXIT_HOLD:   cfg_q.exit_hold_ms     <= cfg_wdata_i;
        tzke_pkg::REG_CORNER_SIZE: cfg_q.exit_corner_size <= cfg_wdata_i[7:0];
        tzke_pkg::REG_DEAD_ZONE:   cfg_q.dpad_dead_zone   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Unpack the incoming sample.
  assign in_d.touch_down   = s_axis_tdata[0];
  assign in_d.touch_x      = s_axis_tdata[9:1];
  assign in_d.touch_y      = s_axis_tdata[18:10];
  assign in_d.time_ms      = s_axis_tdata[50:19];
  assign in_d.menu_open    = s_axis_tdata[51];
  assign in_d.setup_screen = s_axis_tdata[52];

  // The registered sample drains when its events fit into the queue.
  assign consume       = in_vld_q && ((num_events == 3'd0) || q_free);
  assign push          = consume && (num_events != 3'd0);
  assign s_axis_tready = ~in_vld_q | consume;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
  end

  tzke_decode u_decode (
    .sample_i     (in_q),
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .events_o     (events),
    .num_events_o (num_events),
    .state_o      (state_d)
  );

  // Encoder state advances once per decoded sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (consume) begin
      state_q <= state_d;
    end
  end

  tzke_evq u_evq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .events_i     (events),
    .num_events_i (num_events),
    .free_o       (q_free),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .event_o      (ev_out)
  );

  assign m_axis_tdata = {2'b00, ev_out.tap_y, ev_out.tap_x, ev_out.button};
  assign m_axis_tuser = ev_out.kind;
  assign m_axis_tlast = ev_out.last;

  a_exit_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tzke_pkg::KIND_EXIT) |-> m_axis_tlast)
    else $error("exit request not the only event of its sample");

  a_tap_arms_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && (events[0].kind == tzke_pkg::KIND_TAP) |=> state_q.wait_for_release)
    else $error("menu tap did not set the release wait");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> q_free && (num_events <= 3'(tzke_pkg::MaxEvents)))
    else $error("event list written into a busy queue");

endmodule

>>> tb/sv/touch_zone_key_encoder_tb.sv
// Self-checking testbench for the touch zone key encoder: directed table, then random touches.
`timescale 1ns / 1ps

module touch_zone_key_encoder_tb;
  import tzke_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned ItemsPerPhase = 86;

  // One directed row: a sample and, where n is not negative, the typed-in outcome.
  typedef struct {
    sample_t s;
    int      n;
    ev_t     ev;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic [InDataW-1:0]  s_tdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;
  logic                m_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  // Idling pressure of the current phase, in percent.
  int in_idle_pct;
  int out_stall_pct;
  int errors;

  // Encoder state and register copies kept by the testbench.
  logic [NumButtons-1:0] exp_held;
  bit                    exp_touching;
  bit                    exp_wait_lift;
  bit                    exp_armed;
  logic [31:0]           exp_corner_t0;
  logic [15:0]           hold_ms;
  logic [7:0]            corner_px;
  logic [7:0]            dead_zone;

  // Key, tap and exit events still to come from the block, oldest first.
  ev_t events_due[$];

  touch_zone_key_encoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic ev_t key_event(kind_e k, logic [3:0] b, logic [8:0] x, logic [8:0] y);
    ev_t e;
    e.kind   = k;
    e.button = b;
    e.tap_x  = x;
    e.tap_y  = y;
    e.last   = 1'b0;
    return e;
  endfunction

  // Exit corner timer; returns whether the finger is inside the corner.
  function automatic bit track_exit_corner(bit down, logic [8:0] x, logic [8:0] y,
                                           logic [31:0] t, output bit due);
    due = 1'b0;
    if (!down || !(x < corner_px && y < corner_px)) begin
      exp_armed     = 1'b0;
      exp_corner_t0 = '0;
      return 1'b0;
    end
    if (!exp_armed) begin
      exp_armed     = 1'b1;
      exp_corner_t0 = t;
    end else if (t - exp_corner_t0 > {16'd0, hold_ms}) begin
      due = 1'b1;
    end
    return 1'b1;
  endfunction

  // A press or release for each button that differs from the held set, at most MaxEvents of them.
  function automatic void queue_button_changes(logic [NumButtons-1:0] now, ref ev_t q[$]);
    logic [NumButtons-1:0] changed;
    int n;
    changed = now ^ exp_held;
    n = 0;
    for (int b = 0; b < NumButtons; b++) begin
      if (changed[b] && n < MaxEvents) begin
        q.push_back(key_event(now[b] ? KIND_PRESS : KIND_RELEASE, 4'(b), '0, '0));
        n++;
      end
    end
    exp_held = now;
  endfunction

  // Events caused by one touch sample, appended to q.
  function automatic void encode_sample(sample_t s, ref ev_t q[$]);
    bit menu_mode;
    bit press;
    bit due;
    bit in_corner;
    logic [NumButtons-1:0] now;
    int first;
    int dx;
    int dy;
    int dz;
    first     = q.size();
    menu_mode = s.menu_open && !s.setup_screen;
    press     = s.touch_down && !exp_touching;
    due       = 1'b0;
    exp_touching = s.touch_down;
    if (!s.touch_down) exp_wait_lift = 1'b0;

    if (menu_mode) begin
      // Held keys go first; only then taps and the exit corner count.
      if (exp_held != '0) begin
        queue_button_changes('0, q);
      end else begin
        in_corner = track_exit_corner(s.touch_down, s.touch_x, s.touch_y, s.time_ms, due);
        if (due) begin
          q.push_back(key_event(KIND_EXIT, '0, '0, '0));
        end else if (!in_corner && press) begin
          q.push_back(key_event(KIND_TAP, '0, s.touch_x, s.touch_y));
          exp_wait_lift = 1'b1;
        end
      end
    end else begin
      now = '0;
      if (!exp_wait_lift && s.touch_down) begin
        in_corner = track_exit_corner(1'b1, s.touch_x, s.touch_y, s.time_ms, due);
        if (!in_corner) begin
          // Zone map: d-pad on the left, fire and use on the right, keys between.
          dz = int'(dead_zone);
          dx = int'(s.touch_x) - int'(DpadCentreX);
          dy = int'(s.touch_y) - int'(DpadCentreY);
          if (s.touch_x < LeftZoneEnd) begin
            if (dy < -dz) now[BtnUp] = 1'b1;
            else if (dy > dz) now[BtnDown] = 1'b1;
            if (dx < -dz) now[BtnLeft] = 1'b1;
            else if (dx > dz) now[BtnRight] = 1'b1;
          end else if (s.touch_x >= RightZoneBase) begin
            if (s.touch_y < FireUseSplit) now[BtnFire] = 1'b1;
            else now[BtnUse] = 1'b1;
          end else if (s.touch_y < EscapeEnd) begin
            now[BtnEscape] = 1'b1;
          end else if (s.touch_y < EnterEnd) begin
            now[BtnEnter] = 1'b1;
          end else begin
            now[BtnWeapon] = 1'b1;
          end
        end
      end
      if (due) begin
        q.push_back(key_event(KIND_EXIT, '0, '0, '0));
      end else begin
        queue_button_changes(now, q);
      end
    end
    if (q.size() > first) q[q.size()-1].last = 1'b1;
  endfunction

  function automatic row_t dir_row(bit down, int x, int y, logic [31:0] t, bit menu,
                                   bit setup, int n = -1, kind_e k = KIND_PRESS,
                                   int btn = 0, int tx = 0, int ty = 0);
    row_t r;
    r.s.touch_down   = down;
    r.s.touch_x      = x[8:0];
    r.s.touch_y      = y[8:0];
    r.s.time_ms      = t;
    r.s.menu_open    = menu;
    r.s.setup_screen = setup;
    r.n              = n;
    r.ev             = key_event(k, btn[3:0], tx[8:0], ty[8:0]);
    r.ev.last        = 1'b1;
    return r;
  endfunction

  // Offer one sample; on acceptance record what it should produce.
  task automatic drive_sample(sample_t s, int typed_n, ev_t typed_ev);
    ev_t scratch[$];
    while ($urandom_range(99) < in_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, s.setup_screen, s.menu_open, s.time_ms, s.touch_y, s.touch_x,
                 s.touch_down};
    do @(posedge clk); while (!s_tready);
    if (typed_n < 0) begin
      encode_sample(s, events_due);
    end else begin
      encode_sample(s, scratch);
      if (typed_n > 0) events_due.push_back(typed_ev);
    end
  endtask

  // Let every outstanding event arrive, then allow for a sample with none in flight.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // All three registers, one per cycle, written while the block is idle.
  task automatic write_config(logic [15:0] hold, logic [7:0] corner, logic [7:0] dz);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_EXIT_HOLD;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_idx   <= REG_CORNER_SIZE;
    cfg_wdata <= {8'd0, corner};
    @(posedge clk);
    cfg_idx   <= REG_DEAD_ZONE;
    cfg_wdata <= {8'd0, dz};
    @(posedge clk);
    cfg_we    <= 1'b0;
    hold_ms   = hold;
    corner_px = corner;
    dead_zone = dz;
  endtask

  // Output side: check each transaction against the oldest expected event.
  always @(posedge clk) begin
    ev_t got;
    ev_t want;
    if (rst_n && m_tvalid === 1'b1 && m_tready) begin
      got.kind   = kind_e'(m_tuser);
      got.button = m_tdata[3:0];
      got.tap_x  = m_tdata[12:4];
      got.tap_y  = m_tdata[21:13];
      got.last   = m_tlast;
      if (events_due.size() == 0) begin
        $display("%0t: unexpected event: expected none, got kind %0d button %0d %s",
                 $time, got.kind, got.button,
                 $sformatf("tap %0d,%0d last %0b", got.tap_x, got.tap_y, got.last));
        errors++;
      end else begin
        want = events_due.pop_front();
        if (got.kind !== want.kind || got.button !== want.button ||
            got.tap_x !== want.tap_x || got.tap_y !== want.tap_y ||
            got.last !== want.last) begin
          $display("%0t: event mismatch: expected kind %0d button %0d tap %0d,%0d last %0b,",
                   $time, want.kind, want.button, want.tap_x, want.tap_y, want.last);
          $display("%0t:   got kind %0d button %0d tap %0d,%0d last %0b",
                   $time, got.kind, got.button, got.tap_x, got.tap_y, got.last);
          errors++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_t        rows[$];
    sample_t     cur;
    sample_t     noise;
    logic [31:0] clock_ms;
    int          run_left;
    int          mode;
    ev_t         none;

    rst_n     = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_EXIT_HOLD;
    cfg_wdata = '0;
    errors    = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    exp_held      = '0;
    exp_touching  = 1'b0;
    exp_wait_lift = 1'b0;
    exp_armed     = 1'b0;
    exp_corner_t0 = '0;
    hold_ms   = ExitHoldReset;
    corner_px = CornerSizeReset;
    dead_zone = DeadZoneReset;
    none      = key_event(KIND_PRESS, '0, '0, '0);
    cur       = '0;
    clock_ms  = 32'd5000;
    run_left  = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, register defaults: corner timer, every zone, menu taps, timer wrap.
    rows.push_back(dir_row(1, 80, 200, 100, 0, 0, 0));
    rows.push_back(dir_row(1, 0, 0, 1000, 0, 0, 0));
    rows.push_back(dir_row(1, 49, 49, 3000, 0, 0, 0));
    rows.push_back(dir_row(1, 0, 0, 3001, 0, 0, 1, KIND_EXIT));
    rows.push_back(dir_row(1, 479, 0, 3100, 0, 0, 1, KIND_PRESS, BtnFire));
    rows.push_back(dir_row(1, 479, 319, 3200, 0, 0));
    rows.push_back(dir_row(1, 200, 0, 3300, 0, 0));
    rows.push_back(dir_row(1, 200, 100, 3400, 0, 0));
    rows.push_back(dir_row(1, 200, 319, 3500, 0, 0));
    rows.push_back(dir_row(1, 0, 319, 3600, 0, 0));
    rows.push_back(dir_row(1, 159, 177, 3700, 0, 0));
    rows.push_back(dir_row(1, 159, 178, 3800, 0, 0));
    rows.push_back(dir_row(1, 50, 50, 3900, 0, 0));
    rows.push_back(dir_row(0, 479, 319, 4000, 0, 0));
    rows.push_back(dir_row(1, 300, 300, 4100, 1, 0, 1, KIND_TAP, 0, 300, 300));
    rows.push_back(dir_row(1, 300, 300, 4200, 1, 0, 0));
    rows.push_back(dir_row(1, 479, 0, 4300, 0, 0, 0));
    rows.push_back(dir_row(0, 0, 0, 4400, 0, 0, 0));
    rows.push_back(dir_row(1, 479, 0, 4500, 1, 1, 1, KIND_PRESS, BtnFire));
    rows.push_back(dir_row(1, 479, 0, 4600, 1, 0, 1, KIND_RELEASE, BtnFire));
    rows.push_back(dir_row(1, 10, 10, 32'hFFFF_FF00, 1, 0, 0));
    rows.push_back(dir_row(1, 10, 10, 32'h0000_0800, 1, 0, 1, KIND_EXIT));
    rows.push_back(dir_row(0, 479, 319, 32'hFFFF_FFFF, 1, 0, 0));
    rows.push_back(dir_row(1, 0, 0, 32'hFFFF_FFFF, 1, 0, 0));
    rows.push_back(dir_row(1, 479, 319, 32'h0000_0000, 0, 0, 1, KIND_PRESS, BtnUse));
    foreach (rows[i]) drive_sample(rows[i].s, rows[i].n, rows[i].ev);

    // Random part: five register settings; the first and the last phase share the same idling pattern.
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: write_config(16'd0, 8'd255, 8'd0);
          2: write_config(16'hFFFF, 8'd1, 8'd255);
          3: write_config(16'($urandom_range(5000)), 8'($urandom_range(255, 1)),
                          8'($urandom_range(255)));
          default: write_config(ExitHoldReset, CornerSizeReset, DeadZoneReset);
        endcase
      end
      mode = p % 4;
      in_idle_pct   = (mode == 1) ? 75 : (mode == 3) ? 21 : 0;
      out_stall_pct = (mode == 2) ? 75 : (mode == 3) ? 21 : 0;

      for (int i = 0; i < ItemsPerPhase; i++) begin
        // A touch is a run of ticks at one place, now and then moved.
        if (run_left == 0 || $urandom_range(6) == 0) begin
          if ($urandom_range(9) < 3) begin
            cur.touch_x = 9'($urandom_range(corner_px));
            cur.touch_y = 9'($urandom_range(corner_px));
          end else begin
            cur.touch_x = 9'($urandom_range(479));
            cur.touch_y = 9'($urandom_range(319));
          end
        end
        if (run_left == 0) begin
          run_left         = $urandom_range(8, 1);
          cur.touch_down   = ($urandom_range(3) != 0);
          cur.menu_open    = ($urandom_range(3) == 0);
          cur.setup_screen = ($urandom_range(3) == 0);
        end
        run_left--;
        case ($urandom_range(9))
          0:       clock_ms = $urandom;
          1, 2, 3: clock_ms += $urandom_range(70000, 300);
          default: clock_ms += $urandom_range(300);
        endcase
        cur.time_ms = clock_ms;
        if ($urandom_range(9) == 0) begin
          noise.touch_down   = 1'($urandom);
          noise.touch_x      = 9'($urandom_range(479));
          noise.touch_y      = 9'($urandom_range(319));
          noise.time_ms      = $urandom;
          noise.menu_open    = 1'($urandom);
          noise.setup_screen = 1'($urandom);
          drive_sample(noise, -1, none);
        end else begin
          drive_sample(cur, -1, none);
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
